>>> design/smde_pkg.sv
package smde_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_MODULES_DEF      = 16;
  localparam int SWITCHES_PER_ROW_DEF = 8;

  // Fixed geometry of the scanned matrix
  localparam int MAX_LANES       = 8;
  localparam int ROWS_PER_MODULE = 8;
  localparam int COUNTER_W       = 8;
  localparam int ATTACK_W        = 7;
  localparam int EVENT_W         = 9;

  localparam logic [ATTACK_W-1:0]  ATTACK_RESET  = 7'd16;
  localparam logic [COUNTER_W-1:0] COUNTER_RESET = 8'd16;

  // Item slots between the front and back ends
  localparam int QUEUE_DEPTH = 4;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Row kind codes
  localparam logic KIND_MASTER = 1'b0;
  localparam logic KIND_MODULE = 1'b1;

  // Events raised by one scanned row, one bit per lane
  typedef struct packed {
    logic [MAX_LANES-1:0] fired;
    logic [MAX_LANES-1:0] release_m;
    logic                 kind;
    logic                 bank;
    logic [2:0]           row;
  } event_set_t;

  // Index of the lowest set bit; zero for an empty mask
  function automatic logic [2:0] lowest_set(input logic [MAX_LANES-1:0] m);
    logic [2:0] idx;
    idx = '0;
    for (int i = MAX_LANES - 1; i >= 0; i--) begin
      if (m[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

>>> design/switch_matrix_debounce_events.sv
// Switch matrix debounce with press and release events.
// Input channel (in_*): one scanned row of eight active-low switch levels per
// transaction, master row or one switch row of a module bank. Output channel
// (out_*): one event code per transaction, out_last marking the final event
// of its row. Rows that cause no event produce no output transaction.
// cfg_we writes the attack count; write it only while the block is idle.
// Flow: an accepted row reads its counter word into a registered read, is
// debounced in stage 1 and queued, and its first event is loaded into the
// single output event register when the output side is free. Events then
// leave one per cycle while out_ready is high, up to eight per row. Rows
// are accepted one per cycle while the four-entry row queue has room, back
// to back rows on the same counter word being handled by forwarding the
// write-back into the read.
// Reset: all counters read as released with count 16 through per-row valid
// bits, so no clearing pass is needed; attack count returns to 16.
// A stalled receiver holds the current event steady; the queue fills and
// then in_ready drops until events drain.
module switch_matrix_debounce_events import smde_pkg::*; #(
  parameter int NUM_MODULES      = NUM_MODULES_DEF,
  parameter int SWITCHES_PER_ROW = SWITCHES_PER_ROW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ATTACK_W-1:0] cfg_attack_count,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic                in_bank,
  input  logic [2:0]          in_row,
  input  logic [7:0]          in_sample_bits,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [EVENT_W-1:0]  out_event_code,
  output logic                out_last
);

  logic                push_valid;
  event_set_t          push_data;
  logic                pop;
  logic                head_valid;
  event_set_t          head_data;
  logic [QCOUNT_W-1:0] q_count;

  // Accept, counter update and event classification
  smde_front #(
    .NUM_MODULES      (NUM_MODULES),
    .SWITCHES_PER_ROW (SWITCHES_PER_ROW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_attack_count (cfg_attack_count),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_bank          (in_bank),
    .in_row           (in_row),
    .in_sample_bits   (in_sample_bits),
    .q_count          (q_count),
    .push_valid       (push_valid),
    .push_data        (push_data)
  );

  // Rows with pending events
  smde_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .q_count    (q_count)
  );

  // Serial event output
  smde_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_data      (head_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code),
    .out_last       (out_last)
  );

endmodule

>>> design/smde_front.sv
module smde_front import smde_pkg::*; #(
  parameter int NUM_MODULES      = NUM_MODULES_DEF,
  parameter int SWITCHES_PER_ROW = SWITCHES_PER_ROW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ATTACK_W-1:0] cfg_attack_count,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic                in_bank,
  input  logic [2:0]          in_row,
  input  logic [7:0]          in_sample_bits,
  input  logic [QCOUNT_W-1:0] q_count,
  output logic                push_valid,
  output event_set_t          push_data
);

  localparam int NUM_BANKS = (NUM_MODULES + 7) / 8;
  localparam int DEPTH     = 1 + NUM_BANKS * ROWS_PER_MODULE;
  localparam int AW        = $clog2(DEPTH);
  localparam int LANES     = SWITCHES_PER_ROW;
  localparam int WORD_W    = LANES * COUNTER_W;
  localparam logic [WORD_W-1:0] RESET_WORD = {LANES{COUNTER_RESET}};

  logic [ATTACK_W-1:0] attack_r;

  logic [WORD_W-1:0]   mem [DEPTH];
  logic [DEPTH-1:0]    row_valid_r;
  logic [WORD_W-1:0]   rd_word_r;

  logic                s1_valid_r;
  logic [AW-1:0]       s1_addr_r;
  logic                s1_kind_r;
  logic                s1_bank_r;
  logic [2:0]          s1_row_r;
  logic [LANES-1:0]    s1_bits_r;
  logic [LANES-1:0]    s1_en_r;

  logic                in_acc;
  logic [4:0]          addr_full;
  logic                row_ok;
  logic [AW-1:0]       rd_addr;
  logic [LANES-1:0]    lane_en;
  logic                wr_en;
  logic [WORD_W-1:0]   wr_word;
  logic [MAX_LANES-1:0] fired;
  logic [MAX_LANES-1:0] rel;
  logic [QCOUNT_W:0]   occupancy;

  // Accept while the queue can take this item and the one in flight
  assign occupancy = {1'b0, q_count} + {{QCOUNT_W{1'b0}}, s1_valid_r};
  assign in_ready  = occupancy < (QCOUNT_W + 1)'(QUEUE_DEPTH);
  assign in_acc    = in_valid && in_ready;

  // Counter row: master row at 0, then one row per bank and switch row
  always_comb begin
    if (in_kind == KIND_MASTER) begin
      addr_full = 5'd0;
    end else begin
      addr_full = 5'd1 + {1'b0, in_bank, in_row};
    end
    row_ok  = addr_full < 5'(DEPTH);
    rd_addr = row_ok ? addr_full[AW-1:0] : '0;
  end

  // Lanes that map onto a fitted switch
  always_comb begin
    lane_en = '0;
    for (int i = 0; i < LANES; i++) begin
      if (in_kind == KIND_MASTER) begin
        lane_en[i] = 1'b1;
      end else begin
        lane_en[i] = row_ok && ((int'(in_bank) * 8 + i) < NUM_MODULES);
      end
    end
  end

  // Attack register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r <= ATTACK_RESET;
    end else if (cfg_we) begin
      attack_r <= cfg_attack_count;
    end
  end

  // Counter store, written back from stage 1
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= wr_word;
    end
  end

  // Rows never written read as released with the reset count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[s1_addr_r] <= 1'b1;
    end
  end

  // Registered read, with the stage 1 write forwarded on a row match
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (wr_en && (s1_addr_r == rd_addr)) begin
        rd_word_r <= wr_word;
      end else if (row_valid_r[rd_addr]) begin
        rd_word_r <= mem[rd_addr];
      end else begin
        rd_word_r <= RESET_WORD;
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r <= rd_addr;
      s1_kind_r <= in_kind;
      s1_bank_r <= in_bank;
      s1_row_r  <= in_row;
      s1_bits_r <= in_sample_bits[LANES-1:0];
      s1_en_r   <= lane_en;
    end
  end

  // Debounce each lane: count down while low and off, reload on release
  always_comb begin
    logic [COUNTER_W-1:0] c;
    logic [COUNTER_W-1:0] dec;
    logic                 hi;
    wr_word = rd_word_r;
    fired   = '0;
    rel     = '0;
    for (int i = 0; i < LANES; i++) begin
      c   = rd_word_r[i*COUNTER_W +: COUNTER_W];
      hi  = s1_bits_r[i];
      dec = c - 8'd1;
      if (s1_en_r[i]) begin
        if (!hi && !c[COUNTER_W-1]) begin
          wr_word[i*COUNTER_W +: COUNTER_W] = dec;
          fired[i] = dec[COUNTER_W-1];
        end else if (hi && c[COUNTER_W-1]) begin
          wr_word[i*COUNTER_W +: COUNTER_W] = {1'b0, attack_r};
          fired[i] = 1'b1;
          rel[i]   = 1'b1;
        end
      end
    end
  end

  assign wr_en = s1_valid_r && (|s1_en_r);

  // Hand rows with at least one event to the queue
  assign push_valid          = s1_valid_r && (|fired);
  assign push_data.fired     = fired;
  assign push_data.release_m = rel;
  assign push_data.kind      = s1_kind_r;
  assign push_data.bank      = s1_bank_r;
  assign push_data.row       = s1_row_r;

endmodule

>>> design/smde_queue.sv
module smde_queue import smde_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  event_set_t          push_data,
  input  logic                pop,
  output logic                head_valid,
  output event_set_t          head_data,
  output logic [QCOUNT_W-1:0] q_count
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  event_set_t          slot_r [QUEUE_DEPTH];
  logic [QAW-1:0]      wr_ptr_r;
  logic [QAW-1:0]      rd_ptr_r;
  logic [QCOUNT_W-1:0] count_r;
  logic [QCOUNT_W-1:0] count_nxt;
  logic                do_pop;

  assign head_valid = count_r != '0;
  assign head_data  = slot_r[rd_ptr_r];
  assign q_count    = count_r;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push_valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)     rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/smde_back.sv
module smde_back import smde_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  event_set_t         head_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [EVENT_W-1:0] out_event_code,
  output logic               out_last
);

  event_set_t           cur_r;
  logic [MAX_LANES-1:0] mask_r;
  logic                 cur_valid_r;
  logic [2:0]           idx;
  logic                 rel;
  logic                 out_acc;

  // Lowest pending lane goes out first
  assign idx       = lowest_set(mask_r);
  assign rel       = cur_r.release_m[idx];
  assign out_valid = cur_valid_r;
  assign out_last  = (mask_r & (mask_r - 1'b1)) == '0;
  assign out_acc   = out_valid && out_ready;

  // Master: flag bit 7 plus switch index; module: module number then row
  always_comb begin
    if (cur_r.kind == KIND_MASTER) begin
      out_event_code = {rel, 1'b1, 4'b0000, idx};
    end else begin
      out_event_code = {rel, 1'b0, cur_r.bank, idx, cur_r.row};
    end
  end

  // Take the next row when idle or as the final event leaves
  assign pop = head_valid && (!cur_valid_r || (out_acc && out_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
    end else if (out_acc && out_last) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= head_data;
      mask_r <= head_data.fired;
    end else if (out_acc) begin
      mask_r <= mask_r & (mask_r - 1'b1);
    end
  end

endmodule
